### hdl/dxyz_pkg.sv
// Shared types, constants and arithmetic helpers for the depth/IR to XYZI
// back-projection block. No dependencies.

package dxyz_pkg;

    // Counter width for column and row positions
    localparam int MAX_DIM_BITS = 11;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int FRAME_W    = 12;
    localparam int CENTER_W   = 15;
    localparam int INV_W      = 32;
    localparam int CODE_W     = 16;
    localparam int SAMPLE_W   = 16;
    localparam int COORD_W    = 32;

    // Width for comparing pos+1 against the frame size
    localparam int CMP_W  = (MAX_DIM_BITS + 1 > FRAME_W) ? MAX_DIM_BITS + 1 : FRAME_W;
    // Q4 offset magnitude |16*pos - centre|
    localparam int OFF_W  = (MAX_DIM_BITS + 4 > CENTER_W) ? MAX_DIM_BITS + 4 : CENTER_W;
    // offset * depth, then * reciprocal focal length
    localparam int PROD_A_W = OFF_W + SAMPLE_W;
    localparam int PROD_B_W = PROD_A_W + INV_W;
    // Q36 product rounded to Q8
    localparam int RND_SHIFT = 28;
    localparam int MAG_W     = PROD_B_W + 1 - RND_SHIFT;

    localparam logic [FRAME_W-1:0]  RST_FRAME_WIDTH  = FRAME_W'(640);
    localparam logic [FRAME_W-1:0]  RST_FRAME_HEIGHT = FRAME_W'(480);
    localparam logic [CENTER_W-1:0] RST_CENTER_X     = CENTER_W'(5112);
    localparam logic [CENTER_W-1:0] RST_CENTER_Y     = CENTER_W'(3832);
    localparam logic [INV_W-1:0]    RST_INV_FOCAL    = INV_W'(7535030);
    localparam logic [CODE_W-1:0]   RST_CODE         = '0;

    typedef enum logic [2:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_CENTER_X     = 3'd2,
        REG_CENTER_Y     = 3'd3,
        REG_INV_FOCAL_X  = 3'd4,
        REG_INV_FOCAL_Y  = 3'd5,
        REG_NO_SAMPLE    = 3'd6,
        REG_SHADOW       = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [FRAME_W-1:0]  frame_width;
        logic [FRAME_W-1:0]  frame_height;
        logic [CENTER_W-1:0] center_x_q4;
        logic [CENTER_W-1:0] center_y_q4;
        logic [INV_W-1:0]    inv_focal_x;
        logic [INV_W-1:0]    inv_focal_y;
        logic [CODE_W-1:0]   no_sample_code;
        logic [CODE_W-1:0]   shadow_code;
    } cfg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] depth_mm;
        logic [SAMPLE_W-1:0] ir_level;
    } pixel_t;

    typedef struct packed {
        logic                       point_valid;
        logic signed [COORD_W-1:0]  x_mm_q8;
        logic signed [COORD_W-1:0]  y_mm_q8;
        logic [SAMPLE_W-1:0]        z_mm;
        logic [SAMPLE_W-1:0]        intensity;
        logic                       frame_last;
    } point_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_X_OFF,
        ST_MUL_X_FOC,
        ST_MUL_Y_OFF,
        ST_MUL_Y_FOC,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_X_OFF,
        MUL_X_FOC,
        MUL_Y_OFF,
        MUL_Y_FOC
    } mul_sel_t;

    typedef struct packed {
        logic     load_pixel;
        mul_sel_t mul_sel;
        logic     load_x;
        logic     load_result;
    } cmd_t;

    typedef struct packed {
        logic result_busy;
    } status_t;

    localparam logic [PROD_B_W:0] ROUND_BIAS = (PROD_B_W + 1)'(1) << (RND_SHIFT - 1);
    localparam logic [MAG_W-1:0]  POS_LIMIT  = MAG_W'(32'h7FFF_FFFF);
    localparam logic [MAG_W-1:0]  NEG_LIMIT  = MAG_W'(33'h0_8000_0000);

    // Round the Q36 magnitude to Q8 (ties away from zero), apply sign, saturate
    function automatic logic signed [COORD_W-1:0] round_sat(
        input logic [PROD_B_W-1:0] prod,
        input logic                neg
    );
        logic [PROD_B_W:0]  rnd;
        logic [MAG_W-1:0]   mag;
        logic [COORD_W-1:0] res;
        rnd = {1'b0, prod} + ROUND_BIAS;
        mag = rnd[PROD_B_W:RND_SHIFT];
        if (neg)
        begin
            if (mag > NEG_LIMIT)
                res = 32'h8000_0000;
            else
                res = 32'h0 - mag[COORD_W-1:0];
        end
        else
        begin
            if (mag > POS_LIMIT)
                res = 32'h7FFF_FFFF;
            else
                res = mag[COORD_W-1:0];
        end
        return $signed(res);
    endfunction

endpackage

### hdl/dxyz_cfg_regs.sv
// Configuration register bank behind an APB-style slave port.
// Depends on dxyz_pkg.

module dxyz_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dxyz_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [dxyz_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [dxyz_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    output dxyz_pkg::cfg_t                  cfg
);

    dxyz_pkg::cfg_t     cfg_reg;
    dxyz_pkg::reg_idx_t idx;
    logic               wr_en;

    assign idx    = dxyz_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width    <= dxyz_pkg::RST_FRAME_WIDTH;
            cfg_reg.frame_height   <= dxyz_pkg::RST_FRAME_HEIGHT;
            cfg_reg.center_x_q4    <= dxyz_pkg::RST_CENTER_X;
            cfg_reg.center_y_q4    <= dxyz_pkg::RST_CENTER_Y;
            cfg_reg.inv_focal_x    <= dxyz_pkg::RST_INV_FOCAL;
            cfg_reg.inv_focal_y    <= dxyz_pkg::RST_INV_FOCAL;
            cfg_reg.no_sample_code <= dxyz_pkg::RST_CODE;
            cfg_reg.shadow_code    <= dxyz_pkg::RST_CODE;
        end
        else if (wr_en)
        begin
            case (idx)
                dxyz_pkg::REG_FRAME_WIDTH:  cfg_reg.frame_width    <= pwdata[11:0];
                dxyz_pkg::REG_FRAME_HEIGHT: cfg_reg.frame_height   <= pwdata[11:0];
                dxyz_pkg::REG_CENTER_X:     cfg_reg.center_x_q4    <= pwdata[14:0];
                dxyz_pkg::REG_CENTER_Y:     cfg_reg.center_y_q4    <= pwdata[14:0];
                dxyz_pkg::REG_INV_FOCAL_X:  cfg_reg.inv_focal_x    <= pwdata;
                dxyz_pkg::REG_INV_FOCAL_Y:  cfg_reg.inv_focal_y    <= pwdata;
                dxyz_pkg::REG_NO_SAMPLE:    cfg_reg.no_sample_code <= pwdata[15:0];
                dxyz_pkg::REG_SHADOW:       cfg_reg.shadow_code    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            dxyz_pkg::REG_FRAME_WIDTH:  prdata = 32'(cfg_reg.frame_width);
            dxyz_pkg::REG_FRAME_HEIGHT: prdata = 32'(cfg_reg.frame_height);
            dxyz_pkg::REG_CENTER_X:     prdata = 32'(cfg_reg.center_x_q4);
            dxyz_pkg::REG_CENTER_Y:     prdata = 32'(cfg_reg.center_y_q4);
            dxyz_pkg::REG_INV_FOCAL_X:  prdata = cfg_reg.inv_focal_x;
            dxyz_pkg::REG_INV_FOCAL_Y:  prdata = cfg_reg.inv_focal_y;
            dxyz_pkg::REG_NO_SAMPLE:    prdata = 32'(cfg_reg.no_sample_code);
            dxyz_pkg::REG_SHADOW:       prdata = 32'(cfg_reg.shadow_code);
            default:                    prdata = '0;
        endcase
    end

endmodule

### hdl/dxyz_ctrl.sv
// Sequencing state machine: steps the shared multiplier through both axes.
// Depends on dxyz_pkg.

module dxyz_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               depth_valid,
    output logic               depth_stall,
    input  dxyz_pkg::status_t  status,
    output dxyz_pkg::cmd_t     cmd
);

    dxyz_pkg::state_t state_reg;
    dxyz_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= dxyz_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd.load_pixel  = 1'b0;
        cmd.mul_sel     = dxyz_pkg::MUL_NONE;
        cmd.load_x      = 1'b0;
        cmd.load_result = 1'b0;
        depth_stall     = 1'b1;
        case (state_reg)
            dxyz_pkg::ST_IDLE:
            begin
                depth_stall = 1'b0;
                if (depth_valid)
                begin
                    cmd.load_pixel = 1'b1;
                    state_next     = dxyz_pkg::ST_MUL_X_OFF;
                end
            end
            dxyz_pkg::ST_MUL_X_OFF:
            begin
                cmd.mul_sel = dxyz_pkg::MUL_X_OFF;
                state_next  = dxyz_pkg::ST_MUL_X_FOC;
            end
            dxyz_pkg::ST_MUL_X_FOC:
            begin
                cmd.mul_sel = dxyz_pkg::MUL_X_FOC;
                state_next  = dxyz_pkg::ST_MUL_Y_OFF;
            end
            dxyz_pkg::ST_MUL_Y_OFF:
            begin
                cmd.mul_sel = dxyz_pkg::MUL_Y_OFF;
                cmd.load_x  = 1'b1;
                state_next  = dxyz_pkg::ST_MUL_Y_FOC;
            end
            dxyz_pkg::ST_MUL_Y_FOC:
            begin
                cmd.mul_sel = dxyz_pkg::MUL_Y_FOC;
                state_next  = dxyz_pkg::ST_FINISH;
            end
            dxyz_pkg::ST_FINISH:
            begin
                // hold until the output register can take the result
                if (!status.result_busy)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = dxyz_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dxyz_pkg::ST_IDLE;
            end
        endcase
    end

    a_result_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |-> !status.result_busy)
        else $error("result loaded into an occupied output register");

    a_pixel_starts_x: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_pixel |=> (cmd.mul_sel == dxyz_pkg::MUL_X_OFF))
        else $error("accepted pixel did not start the x multiply");

    a_x_before_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_x |=> ##1 (state_reg == dxyz_pkg::ST_FINISH))
        else $error("x coordinate latched out of sequence");

endmodule

### hdl/dxyz_datapath.sv
// Pixel counters, offset logic, shared multiplier, rounding and output register.
// Depends on dxyz_pkg.

module dxyz_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  dxyz_pkg::cfg_t     cfg,
    input  dxyz_pkg::pixel_t   depth_data,
    input  dxyz_pkg::cmd_t     cmd,
    output dxyz_pkg::status_t  status,
    input  logic               xyzi_stall,
    output logic               xyzi_valid,
    output dxyz_pkg::point_t   xyzi_data
);

    localparam int DB = dxyz_pkg::MAX_DIM_BITS;
    localparam int CW = dxyz_pkg::CMP_W;
    localparam int OW = dxyz_pkg::OFF_W;
    localparam int AW = dxyz_pkg::PROD_A_W;
    localparam int BW = dxyz_pkg::PROD_B_W;
    localparam logic [DB-1:0] DIM_MAX = '1;

    logic [DB-1:0] col_reg;
    logic [DB-1:0] row_reg;
    logic          last_col;
    logic          last_row;

    logic [dxyz_pkg::SAMPLE_W-1:0] depth_reg;
    logic [dxyz_pkg::SAMPLE_W-1:0] ir_reg;
    logic                          valid_reg;
    logic                          last_reg;
    logic [OW-1:0]                 off_x_reg;
    logic [OW-1:0]                 off_y_reg;
    logic                          neg_x_reg;
    logic                          neg_y_reg;
    logic [BW-1:0]                 prod_reg;
    logic signed [dxyz_pkg::COORD_W-1:0] x_reg;

    logic [OW-1:0] pos_x;
    logic [OW-1:0] pos_y;
    logic [OW-1:0] cen_x;
    logic [OW-1:0] cen_y;
    logic          neg_x;
    logic          neg_y;
    logic          depth_ok;

    logic [AW-1:0]    op_a;
    logic [dxyz_pkg::INV_W-1:0] op_b;
    logic [BW-1:0]    prod;

    logic              out_valid_reg;
    dxyz_pkg::point_t  out_data_reg;

    assign last_col = (CW'(col_reg) + CW'(1) >= CW'(cfg.frame_width)) || (col_reg == DIM_MAX);
    assign last_row = (CW'(row_reg) + CW'(1) >= CW'(cfg.frame_height)) || (row_reg == DIM_MAX);

    // advance the column once per accepted pixel, and the row at the end of each line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cmd.load_pixel)
        begin
            if (last_col)
            begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : row_reg + DB'(1);
            end
            else
            begin
                col_reg <= col_reg + DB'(1);
            end
        end
    end

    assign pos_x = OW'({col_reg, 4'b0000});
    assign pos_y = OW'({row_reg, 4'b0000});
    assign cen_x = OW'(cfg.center_x_q4);
    assign cen_y = OW'(cfg.center_y_q4);
    assign neg_x = pos_x < cen_x;
    assign neg_y = pos_y < cen_y;
    assign depth_ok = (depth_data.depth_mm != '0) &&
                      (depth_data.depth_mm != cfg.no_sample_code) &&
                      (depth_data.depth_mm != cfg.shadow_code);

    always_ff @(posedge clk)
    begin
        if (cmd.load_pixel)
        begin
            depth_reg <= depth_data.depth_mm;
            ir_reg    <= depth_data.ir_level;
            valid_reg <= depth_ok;
            last_reg  <= last_col && last_row;
            neg_x_reg <= neg_x;
            neg_y_reg <= neg_y;
            off_x_reg <= neg_x ? cen_x - pos_x : pos_x - cen_x;
            off_y_reg <= neg_y ? cen_y - pos_y : pos_y - cen_y;
        end
    end

    // shared multiplier operand select
    always_comb
    begin
        case (cmd.mul_sel)
            dxyz_pkg::MUL_X_OFF:
            begin
                op_a = AW'(off_x_reg);
                op_b = 32'(depth_reg);
            end
            dxyz_pkg::MUL_X_FOC:
            begin
                op_a = prod_reg[AW-1:0];
                op_b = cfg.inv_focal_x;
            end
            dxyz_pkg::MUL_Y_OFF:
            begin
                op_a = AW'(off_y_reg);
                op_b = 32'(depth_reg);
            end
            dxyz_pkg::MUL_Y_FOC:
            begin
                op_a = prod_reg[AW-1:0];
                op_b = cfg.inv_focal_y;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod = BW'(op_a) * BW'(op_b);

    always_ff @(posedge clk)
    begin
        if (cmd.mul_sel != dxyz_pkg::MUL_NONE)
            prod_reg <= prod;
        if (cmd.load_x)
            x_reg <= dxyz_pkg::round_sat(prod_reg, neg_x_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_result)
            out_valid_reg <= 1'b1;
        else if (!xyzi_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            out_data_reg.point_valid <= valid_reg;
            out_data_reg.x_mm_q8     <= valid_reg ? x_reg : '0;
            out_data_reg.y_mm_q8     <= valid_reg ?
                                        dxyz_pkg::round_sat(prod_reg, neg_y_reg) : '0;
            out_data_reg.z_mm        <= valid_reg ? depth_reg : '0;
            out_data_reg.intensity   <= ir_reg;
            out_data_reg.frame_last  <= last_reg;
        end
    end

    assign status.result_busy = out_valid_reg && xyzi_stall;
    assign xyzi_valid         = out_valid_reg;
    assign xyzi_data          = out_data_reg;

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |=> out_valid_reg)
        else $error("loaded result not presented");

    a_invalid_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.point_valid) |->
        (out_data_reg.x_mm_q8 == '0 && out_data_reg.y_mm_q8 == '0 &&
         out_data_reg.z_mm == '0))
        else $error("invalid point carries non-zero coordinates");

endmodule

### hdl/depth_ir_to_xyzi_points_top.sv
// Top level of the depth/IR to XYZI point back-projection block.
// Depends on dxyz_pkg, dxyz_cfg_regs, dxyz_ctrl and dxyz_datapath.
//
//  Channel   Direction  Handshake                 Payload
//  --------  ---------  ------------------------  --------------------------
//  depth     in         depth_valid/depth_stall   dxyz_pkg::pixel_t
//  xyzi      out        xyzi_valid/xyzi_stall     dxyz_pkg::point_t
//  config    in         APB (psel/penable/pwrite) paddr, pwdata, prdata
//
// Sequence: a pixel is taken in idle, passes the single shared multiplier
// (offset*depth then *1/f, per axis), and the finishing step loads the
// output register. The multiplier sequence sets the rate while the output
// is not stalled. The result appears in the cycle after the finishing step;
// the next pixel is taken while that result waits behind a stalled output.
// Reset: rst_n clears the state machine, pixel counters, output valid and
// loads the register defaults (640x480 frame). No clearing pass.
// Stalls: hold the finished point in the output register; the sequencer
// waits in its finishing step until the register is free.

module depth_ir_to_xyzi_points_top (
    input  logic                            clk,
    input  logic                            rst_n,
    // pixel input
    input  logic                            depth_valid,
    output logic                            depth_stall,
    input  dxyz_pkg::pixel_t                depth_data,
    // point output
    output logic                            xyzi_valid,
    input  logic                            xyzi_stall,
    output dxyz_pkg::point_t                xyzi_data,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dxyz_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [dxyz_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [dxyz_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);

    dxyz_pkg::cfg_t    cfg;
    dxyz_pkg::cmd_t    cmd;
    dxyz_pkg::status_t status;

    // register bank: the user must write it only while no transfer is in flight; the bank itself does not enforce this
    dxyz_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer: accepts a pixel in idle, then steps the multiplier
    dxyz_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .depth_valid (depth_valid),
        .depth_stall (depth_stall),
        .status      (status),
        .cmd         (cmd)
    );

    // counters, arithmetic and the output register
    dxyz_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .depth_data (depth_data),
        .cmd        (cmd),
        .status     (status),
        .xyzi_stall (xyzi_stall),
        .xyzi_valid (xyzi_valid),
        .xyzi_data  (xyzi_data)
    );

endmodule
